FILE: src/humidity_voltage_to_rh_unit_macros.svh
// Assertion macros used by the humidity conversion RTL.
`ifndef HUMIDITY_VOLTAGE_TO_RH_UNIT_MACROS_SVH
`define HUMIDITY_VOLTAGE_TO_RH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HVRH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hvrh same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HVRH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hvrh next-cycle check failed");

`endif

FILE: src/hvrh_pkg.sv
// Shared widths, constants and types of the humidity conversion pipeline.
`default_nettype none
package hvrh_pkg;

    localparam int VoltW    = 21;
    localparam int TempW    = 15;
    localparam int OffW     = 21;
    localparam int GainW    = 17;
    localparam int GainEffW = 16;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 21;
    localparam int RhW      = 14;
    localparam int StatW    = 2;
    localparam int FiveVW   = 24;
    localparam int TdivW    = 24;
    localparam int Num0W    = 31;
    localparam int NumW     = 54;
    localparam int DenW     = 40;
    localparam int QuotBits = 14;

    localparam logic [OffW-1:0]  OffsetDefault = 21'd850000;
    localparam logic [OffW-1:0]  OffsetMin     = 21'd500000;
    localparam logic [OffW-1:0]  OffsetMax     = 21'd1500000;
    localparam logic [GainW-1:0] GainDefault   = 17'd31000;
    localparam logic [GainW-1:0] GainMin       = 17'd20000;
    localparam logic [GainW-1:0] GainMax       = 17'd50000;

    localparam logic signed [TdivW:0] TdivBase  = 25'sd10546000;
    localparam logic signed [TdivW:0] TdivSlope = 25'sd216;
    localparam logic [TdivW-1:0]      TdivScale = 24'd10000000;
    localparam logic [Num0W-1:0]      PctScale  = 31'd100;

    localparam logic [RhW-1:0] LimitError = 14'd11000;
    localparam logic [RhW-1:0] LimitClamp = 14'd10010;

    typedef enum logic [CfgIdxW-1:0] {
        CfgOffset = 1'b0,
        CfgGain   = 1'b1
    } hvrh_cfg_idx_t;

    typedef enum logic [StatW-1:0] {
        StatusNormal = 2'd0,
        StatusClamp  = 2'd1,
        StatusError  = 2'd2
    } hvrh_status_t;

    typedef struct packed {
        logic            neg;
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
    } hvrh_frac_t;

    typedef struct packed {
        logic                err;
        logic [QuotBits-1:0] quot;
        logic [NumW-1:0]     rem;
        logic [DenW-1:0]     den;
    } hvrh_div_t;

    typedef struct packed {
        logic [RhW-1:0] rh;
        hvrh_status_t   status;
    } hvrh_res_t;

endpackage
`default_nettype wire

FILE: src/humidity_voltage_to_rh_unit.sv
// Depth: prep, range check, 14 restoring divider stages and the output register.
// Throughput: one transaction per cycle while the pipeline is not stalled.
// A stalled output fills a one-entry skid register, after which the input stalls.
// Reset clears all valid bits and loads the calibration registers with their defaults.
// Top level of the humidity voltage to relative humidity conversion.
`default_nettype none
module humidity_voltage_to_rh_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [hvrh_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [hvrh_pkg::CfgDataW-1:0]     cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [hvrh_pkg::VoltW-1:0]        voltage_uv,
    input  wire logic signed [hvrh_pkg::TempW-1:0] temp_centi,
    input  wire logic                              temp_valid,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [hvrh_pkg::RhW-1:0]               rh_centi,
    output logic [hvrh_pkg::StatW-1:0]             status
);

    logic [hvrh_pkg::OffW-1:0]  offset_reg;
    logic [hvrh_pkg::GainW-1:0] gain_reg;
    logic                       pipe_en;
    logic                       in_take;
    logic                       frac_valid;
    hvrh_pkg::hvrh_frac_t       frac;
    logic                       quot_valid;
    hvrh_pkg::hvrh_div_t        quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= hvrh_pkg::OffsetDefault;
            gain_reg   <= hvrh_pkg::GainDefault;
        end
        else if (cfg_we)
        begin
            case (hvrh_pkg::hvrh_cfg_idx_t'(cfg_index))
                hvrh_pkg::CfgOffset:
                begin
                    offset_reg <= cfg_data[hvrh_pkg::OffW-1:0];
                end
                hvrh_pkg::CfgGain:
                begin
                    gain_reg <= cfg_data[hvrh_pkg::GainW-1:0];
                end
                default:
                begin
                    offset_reg <= offset_reg;
                end
            endcase
        end
    end

    assign in_stall = !pipe_en;
    assign in_take  = in_valid && pipe_en;

    hvrh_prep u_prep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_take    (in_take),
        .voltage_uv (voltage_uv),
        .temp_centi (temp_centi),
        .temp_valid (temp_valid),
        .offset_cfg (offset_reg),
        .gain_cfg   (gain_reg),
        .frac_valid (frac_valid),
        .frac       (frac)
    );

    hvrh_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .frac_valid (frac_valid),
        .frac       (frac),
        .quot_valid (quot_valid),
        .quot       (quot)
    );

    hvrh_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .quot_valid (quot_valid),
        .quot       (quot),
        .out_stall  (out_stall),
        .pipe_en    (pipe_en),
        .out_valid  (out_valid),
        .rh_centi   (rh_centi),
        .status     (status)
    );

endmodule
`default_nettype wire

FILE: src/hvrh_prep.sv
// Front stages: calibration, voltage offset, temperature divisor and the three products.
`default_nettype none
module hvrh_prep
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_take,
    input  wire logic [hvrh_pkg::VoltW-1:0]      voltage_uv,
    input  wire logic signed [hvrh_pkg::TempW-1:0] temp_centi,
    input  wire logic                            temp_valid,
    input  wire logic [hvrh_pkg::OffW-1:0]       offset_cfg,
    input  wire logic [hvrh_pkg::GainW-1:0]      gain_cfg,
    output logic                                 frac_valid,
    output hvrh_pkg::hvrh_frac_t                 frac
);

    logic [hvrh_pkg::OffW-1:0]       off_eff;
    logic [hvrh_pkg::GainW-1:0]      gain_sel;
    logic [hvrh_pkg::FiveVW-1:0]     five_v;
    logic signed [hvrh_pkg::TdivW:0] tdiv_s;

    logic                          s1_valid_reg;
    logic                          s1_neg_reg;
    logic                          s1_tv_reg;
    logic [hvrh_pkg::FiveVW-1:0]   s1_diff_reg;
    logic [hvrh_pkg::GainEffW-1:0] s1_gain_reg;
    logic [hvrh_pkg::TdivW-1:0]    s1_tdiv_reg;

    logic                          s2_valid_reg;
    logic                          s2_neg_reg;
    logic                          s2_tv_reg;
    logic [hvrh_pkg::Num0W-1:0]    s2_num_reg;
    logic [hvrh_pkg::DenW-1:0]     s2_den_reg;

    logic                          s3_valid_reg;
    hvrh_pkg::hvrh_frac_t          s3_frac_reg;
    hvrh_pkg::hvrh_frac_t          s3_frac_next;

    always_comb
    begin
        off_eff = offset_cfg;
        if (offset_cfg < hvrh_pkg::OffsetMin || offset_cfg > hvrh_pkg::OffsetMax)
        begin
            off_eff = hvrh_pkg::OffsetDefault;
        end
        gain_sel = gain_cfg;
        if (gain_cfg < hvrh_pkg::GainMin || gain_cfg > hvrh_pkg::GainMax)
        begin
            gain_sel = hvrh_pkg::GainDefault;
        end
        five_v = hvrh_pkg::FiveVW'({voltage_uv, 2'b00}) + hvrh_pkg::FiveVW'(voltage_uv);
        tdiv_s = hvrh_pkg::TdivBase
               - (hvrh_pkg::TdivW + 1)'(temp_centi) * hvrh_pkg::TdivSlope;
    end

    always_comb
    begin
        s3_frac_next.neg = s2_neg_reg;
        s3_frac_next.den = s2_den_reg;
        if (s2_tv_reg)
        begin
            s3_frac_next.num = hvrh_pkg::NumW'(s2_num_reg)
                             * hvrh_pkg::NumW'(hvrh_pkg::TdivScale);
        end
        else
        begin
            s3_frac_next.num = hvrh_pkg::NumW'(s2_num_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg  <= five_v < hvrh_pkg::FiveVW'(off_eff);
            s1_tv_reg   <= temp_valid;
            s1_diff_reg <= five_v - hvrh_pkg::FiveVW'(off_eff);
            s1_gain_reg <= gain_sel[hvrh_pkg::GainEffW-1:0];
            s1_tdiv_reg <= tdiv_s[hvrh_pkg::TdivW-1:0];

            s2_neg_reg <= s1_neg_reg;
            s2_tv_reg  <= s1_tv_reg;
            s2_num_reg <= hvrh_pkg::Num0W'(s1_diff_reg) * hvrh_pkg::PctScale;
            if (s1_tv_reg)
            begin
                s2_den_reg <= hvrh_pkg::DenW'(s1_gain_reg) * hvrh_pkg::DenW'(s1_tdiv_reg);
            end
            else
            begin
                s2_den_reg <= hvrh_pkg::DenW'(s1_gain_reg);
            end

            s3_frac_reg <= s3_frac_next;
        end
    end

    assign frac_valid = s3_valid_reg;
    assign frac       = s3_frac_reg;

endmodule
`default_nettype wire

FILE: src/hvrh_div_stage.sv
// One restoring division step that resolves a single quotient bit.
`default_nettype none
module hvrh_div_stage
#(
    parameter int SHIFT = hvrh_pkg::QuotBits - 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                valid_in,
    input  wire hvrh_pkg::hvrh_div_t d_in,
    output logic                     valid_out,
    output hvrh_pkg::hvrh_div_t      d_out
);

    localparam int WideW = hvrh_pkg::NumW + 1;

    logic [WideW-1:0]    den_sh;
    logic                ge;
    hvrh_pkg::hvrh_div_t d_next;
    logic                valid_reg;
    hvrh_pkg::hvrh_div_t d_reg;

    always_comb
    begin
        den_sh = WideW'(d_in.den) << SHIFT;
        ge     = {1'b0, d_in.rem} >= den_sh;
        d_next = d_in;
        d_next.quot[SHIFT] = ge;
        if (ge)
        begin
            d_next.rem = d_in.rem - den_sh[hvrh_pkg::NumW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;

endmodule
`default_nettype wire

FILE: src/hvrh_div.sv
// Pipelined divider: range check followed by one stage per quotient bit.
`default_nettype none
module hvrh_div
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 frac_valid,
    input  wire hvrh_pkg::hvrh_frac_t frac,
    output logic                      quot_valid,
    output hvrh_pkg::hvrh_div_t       quot
);

    localparam int Stages = hvrh_pkg::QuotBits;
    localparam int WideW  = hvrh_pkg::NumW + 1;

    logic                pre_valid_reg;
    hvrh_pkg::hvrh_div_t pre_reg;
    hvrh_pkg::hvrh_div_t pre_next;
    logic [WideW-1:0]    den_full;

    logic                chain_valid [Stages+1];
    hvrh_pkg::hvrh_div_t chain_d     [Stages+1];

    always_comb
    begin
        den_full      = WideW'(frac.den) << Stages;
        pre_next.err  = frac.neg || ({1'b0, frac.num} >= den_full);
        pre_next.quot = '0;
        pre_next.rem  = frac.num;
        pre_next.den  = frac.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= frac_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
        end
    end

    assign chain_valid[0] = pre_valid_reg;
    assign chain_d[0]     = pre_reg;

    for (genvar k = 0; k < Stages; k++)
    begin : g_step
        hvrh_div_stage
        #(
            .SHIFT (Stages - 1 - k)
        )
        u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (chain_valid[k]),
            .d_in      (chain_d[k]),
            .valid_out (chain_valid[k+1]),
            .d_out     (chain_d[k+1])
        );
    end

    assign quot_valid = chain_valid[Stages];
    assign quot       = chain_d[Stages];

endmodule
`default_nettype wire

FILE: src/hvrh_out.sv
// Limit checks and the output register with its skid stage.
`default_nettype none
`include "humidity_voltage_to_rh_unit_macros.svh"
module hvrh_out
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      quot_valid,
    input  wire hvrh_pkg::hvrh_div_t       quot,
    input  wire logic                      out_stall,
    output logic                           pipe_en,
    output logic                           out_valid,
    output logic [hvrh_pkg::RhW-1:0]       rh_centi,
    output logic [hvrh_pkg::StatW-1:0]     status
);

    hvrh_pkg::hvrh_res_t fin;
    logic                rem_nz;
    logic                over_err;
    logic                over_clamp;
    logic                out_free;
    logic                res_err;
    logic                res_clamp;

    logic                out_valid_reg;
    logic                skid_valid_reg;
    hvrh_pkg::hvrh_res_t out_res_reg;
    hvrh_pkg::hvrh_res_t skid_res_reg;

    always_comb
    begin
        rem_nz     = quot.rem != '0;
        over_err   = quot.quot > hvrh_pkg::LimitError
                  || (quot.quot == hvrh_pkg::LimitError && rem_nz);
        over_clamp = quot.quot > hvrh_pkg::LimitClamp
                  || (quot.quot == hvrh_pkg::LimitClamp && rem_nz);
        if (quot.err || over_err)
        begin
            fin.rh     = '0;
            fin.status = hvrh_pkg::StatusError;
        end
        else if (over_clamp)
        begin
            fin.rh     = hvrh_pkg::LimitClamp;
            fin.status = hvrh_pkg::StatusClamp;
        end
        else
        begin
            fin.rh     = quot.quot;
            fin.status = hvrh_pkg::StatusNormal;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign pipe_en  = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (quot_valid)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (quot_valid)
        begin
            if (out_free)
            begin
                out_res_reg <= fin;
            end
            else
            begin
                skid_res_reg <= fin;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign rh_centi  = out_res_reg.rh;
    assign status    = out_res_reg.status;

    assign res_err   = out_valid_reg && out_res_reg.status == hvrh_pkg::StatusError;
    assign res_clamp = out_valid_reg && out_res_reg.status == hvrh_pkg::StatusClamp;

    `HVRH_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `HVRH_ASSERT_NXT(a_skid_holds, clk, rst_n, skid_valid_reg && out_stall, skid_valid_reg)
    `HVRH_ASSERT_IMP(a_error_zero, clk, rst_n, res_err, out_res_reg.rh == '0)
    `HVRH_ASSERT_IMP(a_clamp_value, clk, rst_n, res_clamp, out_res_reg.rh == hvrh_pkg::LimitClamp)

endmodule
`default_nettype wire

FILE: test/humidity_voltage_to_rh_unit_tb.sv
// Self-checking testbench for the humidity voltage to relative humidity conversion unit.
`timescale 1ns / 1ps
module humidity_voltage_to_rh_unit_tb;

    typedef longint unsigned u64_t;

    localparam int CycleLimit = 500000;
    localparam int DrainCycles = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [hvrh_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [hvrh_pkg::CfgDataW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [hvrh_pkg::VoltW-1:0] voltage_uv = '0;
    logic signed [hvrh_pkg::TempW-1:0] temp_centi = '0;
    logic temp_valid = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [hvrh_pkg::RhW-1:0] rh_centi;
    logic [hvrh_pkg::StatW-1:0] status;

    logic [hvrh_pkg::OffW-1:0] offset_shadow = hvrh_pkg::OffsetDefault;
    logic [hvrh_pkg::GainW-1:0] gain_shadow = hvrh_pkg::GainDefault;
    hvrh_pkg::hvrh_res_t rh_expected_q[$];
    hvrh_pkg::hvrh_res_t front_rh;
    int err_count = 0;
    int cycle_count = 0;
    int rx_hold_cycles = 0;
    int stall_left = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    humidity_voltage_to_rh_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .voltage_uv (voltage_uv),
        .temp_centi (temp_centi),
        .temp_valid (temp_valid),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rh_centi   (rh_centi),
        .status     (status)
    );

    always #2 clk = ~clk;

    function automatic u64_t eff_offset();
        if (offset_shadow < hvrh_pkg::OffsetMin || offset_shadow > hvrh_pkg::OffsetMax)
        begin
            return u64_t'(hvrh_pkg::OffsetDefault);
        end
        return u64_t'(offset_shadow);
    endfunction

    function automatic u64_t eff_gain();
        if (gain_shadow < hvrh_pkg::GainMin || gain_shadow > hvrh_pkg::GainMax)
        begin
            return u64_t'(hvrh_pkg::GainDefault);
        end
        return u64_t'(gain_shadow);
    endfunction

    function automatic hvrh_pkg::hvrh_res_t humidity_from_sample(
        input logic [hvrh_pkg::VoltW-1:0] v,
        input logic signed [hvrh_pkg::TempW-1:0] t,
        input logic tv);
        hvrh_pkg::hvrh_res_t res;
        u64_t off;
        u64_t five_v;
        u64_t num;
        u64_t den;
        u64_t q;
        u64_t r;
        longint tdiv;
        off = eff_offset();
        five_v = 5 * u64_t'(v);
        res.rh = '0;
        res.status = hvrh_pkg::StatusError;
        if (five_v < off)
        begin
            return res;
        end
        num = 100 * (five_v - off);
        den = eff_gain();
        if (tv)
        begin
            tdiv = longint'(hvrh_pkg::TdivBase) - longint'(hvrh_pkg::TdivSlope) * longint'(t);
            num = num * u64_t'(hvrh_pkg::TdivScale);
            den = den * u64_t'(tdiv);
        end
        q = num / den;
        r = num % den;
        if (q > hvrh_pkg::LimitError || (q == hvrh_pkg::LimitError && r != 0))
        begin
            res.status = hvrh_pkg::StatusError;
        end
        else if (q > hvrh_pkg::LimitClamp || (q == hvrh_pkg::LimitClamp && r != 0))
        begin
            res.rh = hvrh_pkg::LimitClamp;
            res.status = hvrh_pkg::StatusClamp;
        end
        else
        begin
            res.rh = q[hvrh_pkg::RhW-1:0];
            res.status = hvrh_pkg::StatusNormal;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            return 0;
        end
        if (sel < 90)
        begin
            return int'($urandom_range(1, 3));
        end
        if (sel < 98)
        begin
            return int'($urandom_range(4, 12));
        end
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [hvrh_pkg::VoltW-1:0] pick_voltage();
        int unsigned sel;
        longint centi;
        longint v;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            return hvrh_pkg::VoltW'($urandom_range(0, 2097151));
        end
        if (sel == 1)
        begin
            return hvrh_pkg::VoltW'($urandom_range(0, 1250000));
        end
        if (sel == 2)
        begin
            case ($urandom_range(0, 2))
                0: centi = 0;
                1: centi = longint'(hvrh_pkg::LimitClamp);
                default: centi = longint'(hvrh_pkg::LimitError);
            endcase
            centi = centi + longint'($urandom_range(0, 4)) - 2;
        end
        else
        begin
            centi = longint'($urandom_range(0, 12000)) - 500;
        end
        v = (longint'(eff_offset()) + centi * longint'(eff_gain()) / 100) / 5;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 2097151)
        begin
            v = 2097151;
        end
        return v[hvrh_pkg::VoltW-1:0];
    endfunction

    function automatic logic signed [hvrh_pkg::TempW-1:0] pick_temp();
        int t;
        if ($urandom_range(0, 9) < 7)
        begin
            t = int'($urandom_range(0, 20000)) - 5000;
        end
        else
        begin
            t = int'($urandom_range(0, 32767));
        end
        return t[hvrh_pkg::TempW-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 40)
        begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    task automatic send_sample(input logic [hvrh_pkg::VoltW-1:0] v,
                               input logic signed [hvrh_pkg::TempW-1:0] t,
                               input logic tv);
        int gap;
        @(negedge clk);
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        voltage_uv <= v;
        temp_centi <= t;
        temp_valid <= tv;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        rh_expected_q.push_back(humidity_from_sample(v, t, tv));
    endtask

    task automatic send_random_samples(input int count);
        repeat (count)
        begin
            send_sample(pick_voltage(), pick_temp(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rh_expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_calibration(input hvrh_pkg::hvrh_cfg_idx_t idx,
                                     input logic [hvrh_pkg::CfgDataW-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == hvrh_pkg::CfgOffset)
        begin
            offset_shadow = data[hvrh_pkg::OffW-1:0];
        end
        else
        begin
            gain_shadow = data[hvrh_pkg::GainW-1:0];
        end
    endtask

    task automatic test_directed_limits();
        send_sample(21'd0, 15'sd0, 1'b0);
        send_sample(21'd169999, 15'sd0, 1'b0);
        send_sample(21'd170000, 15'sd0, 1'b0);
        send_sample(21'd790620, 15'sd0, 1'b0);
        send_sample(21'd790621, 15'sd0, 1'b0);
        send_sample(21'd852000, 15'sd0, 1'b0);
        send_sample(21'd852001, 15'sd0, 1'b0);
        send_sample(21'h1FFFFF, 15'sd16383, 1'b1);
        send_sample(21'h1FFFFF, 15'sd0, 1'b0);
        send_sample(21'd400000, -15'sd16384, 1'b1);
        send_sample(21'd400000, 15'sd16383, 1'b1);
        send_sample(21'd400000, 15'sd0, 1'b1);
        send_sample(21'd400000, -15'sd5000, 1'b1);
        send_sample(21'd400000, 15'sd15000, 1'b1);
        send_sample(21'd400000, 15'sd16383, 1'b0);
        send_sample(21'd1250000, 15'sd2500, 1'b0);
        send_sample(21'd500000, 15'sd2500, 1'b1);
        send_sample(21'd500000, -15'sd1, 1'b1);
        send_sample(21'h155555, 15'h2AAA, 1'b1);
        send_sample(21'h0AAAAA, 15'h5555, 1'b1);
        send_sample(21'd700000, 15'sd0, 1'b1);
        wait_all_results();
    endtask

    task automatic test_calibration_windows();
        logic [hvrh_pkg::CfgDataW-1:0] offsets [10];
        logic [hvrh_pkg::CfgDataW-1:0] gains [10];
        offsets = '{21'd0, 21'd499999, 21'd500000, 21'd1500000, 21'd1500001,
                    21'h1FFFFF, 21'd500000, 21'd1500000, 21'd1234567, 21'd850000};
        gains = '{21'd0, 21'd19999, 21'd20000, 21'd50000, 21'd50001,
                  21'h1FFFFF, 21'd50000, 21'd20000, 21'h100000 | 21'd25000, 21'd31000};
        for (int i = 0; i < 10; i++)
        begin
            write_calibration(hvrh_pkg::CfgOffset, offsets[i]);
            write_calibration(hvrh_pkg::CfgGain, gains[i]);
            send_random_samples(40);
            wait_all_results();
        end
    endtask

    task automatic test_random_samples();
        for (int i = 0; i < 6; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_calibration(hvrh_pkg::CfgOffset,
                                  hvrh_pkg::CfgDataW'($urandom_range(0, 2097151)));
                write_calibration(hvrh_pkg::CfgGain,
                                  hvrh_pkg::CfgDataW'($urandom_range(0, 2097151)));
            end
            else
            begin
                write_calibration(hvrh_pkg::CfgOffset,
                                  hvrh_pkg::CfgDataW'($urandom_range(500000, 1500000)));
                write_calibration(hvrh_pkg::CfgGain,
                                  hvrh_pkg::CfgDataW'($urandom_range(20000, 50000)));
            end
            send_random_samples(100);
            wait_all_results();
        end
        write_calibration(hvrh_pkg::CfgOffset, hvrh_pkg::CfgDataW'(hvrh_pkg::OffsetDefault));
        write_calibration(hvrh_pkg::CfgGain, hvrh_pkg::CfgDataW'(hvrh_pkg::GainDefault));
    endtask

    task automatic test_full_backpressure();
        tx_idle_en = 1'b0;
        rx_hold_cycles = 300;
        send_random_samples(80);
        tx_idle_en = 1'b1;
        wait_all_results();
        send_random_samples(40);
        wait_all_results();
    endtask

    task automatic test_streaming();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_samples(150);
        wait_all_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            rx_hold_cycles = rx_hold_cycles - 1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (rh_expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result rh=%0d status=%0d with nothing expected",
                                          rh_centi, status));
            end
            else
            begin
                front_rh = rh_expected_q.pop_front();
                if (rh_centi !== front_rh.rh)
                begin
                    report_mismatch($sformatf("rh_centi %0d, expected %0d",
                                              rh_centi, front_rh.rh));
                end
                if (status !== front_rh.status)
                begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, front_rh.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("humidity_voltage_to_rh_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(posedge clk);
        test_directed_limits();
        test_calibration_windows();
        test_random_samples();
        test_full_backpressure();
        test_streaming();
        wait_all_results();
        repeat (DrainCycles) @(posedge clk);
        if (rh_expected_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", rh_expected_q.size()));
        end
        if (err_count == 0)
        begin
            $display("humidity_voltage_to_rh_unit_tb: done, clean");
        end
        else
        begin
            $display("humidity_voltage_to_rh_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/hvrh_pkg.sv
src/hvrh_prep.sv
src/hvrh_div_stage.sv
src/hvrh_div.sv
src/hvrh_out.sv
src/humidity_voltage_to_rh_unit.sv
test/humidity_voltage_to_rh_unit_tb.sv
